>>> design/bcc_pkg.sv
// bcc_pkg: shared constants, state codes and beat types for the battery charge controller
// no dependencies; used by bcc_filter, bcc_mode and battery_charge_controller

package bcc_pkg;

    // filter weight 1/2^FILTER_SHIFT, accumulator scaled by 2^FILTER_SHIFT
    localparam int FILTER_SHIFT = 4;
    localparam int DAC_BITS     = 8;

    localparam int SAMPLE_W = 13;
    localparam int ACC_W    = 18;
    localparam int MV_W     = 15;
    localparam int CODE_W   = 8;
    localparam int THR_W    = 14;
    localparam int STATE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CODE_W-1:0] DAC_MASK = CODE_W'((64'd1 << DAC_BITS) - 64'd1);

    // run states
    localparam logic [STATE_W-1:0] ST_NONE       = 3'd0;
    localparam logic [STATE_W-1:0] ST_CC         = 3'd1;
    localparam logic [STATE_W-1:0] ST_CV         = 3'd2;
    localparam logic [STATE_W-1:0] ST_CHARGED    = 3'd3;
    localparam logic [STATE_W-1:0] ST_DIS        = 3'd4;
    localparam logic [STATE_W-1:0] ST_DISCHARGED = 3'd5;
    localparam logic [STATE_W-1:0] ST_HIGHVOLT   = 3'd6;
    localparam logic [STATE_W-1:0] ST_TOOLOW     = 3'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_CODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MV      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIS_STOP_MV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOO_LOW_MV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_CHG_MV    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_DIS_MV    = 3'd6;

    typedef struct packed {
        logic [CODE_W-1:0] charge_code;
        logic [CODE_W-1:0] discharge_code;
        logic [THR_W-1:0]  target_mv;
        logic [MV_W-1:0]   dis_floor_mv;       // signed
        logic [THR_W-1:0]  too_low_mv;
        logic [THR_W-1:0]  open_charge_mv;
        logic [THR_W-1:0]  open_discharge_mv;
    } bcc_cfg_t;

    typedef struct packed {
        logic                sample_valid;
        logic [SAMPLE_W-1:0] adc_sample;       // signed
        logic                charge_mode;
        logic                over_voltage;
    } bcc_item_t;

    typedef struct packed {
        logic [MV_W-1:0]    battery_mv;        // signed
        logic               amp_enable;
        logic [CODE_W-1:0]  dac_code;
        logic [STATE_W-1:0] charge_state;
    } bcc_result_t;

endpackage

>>> design/bcc_filter.sv
// bcc_filter: 15/16 iir filter on the adc samples, accumulator and primed flag
// depends on bcc_pkg

module bcc_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic                                sample_valid,
    input  logic signed [bcc_pkg::SAMPLE_W-1:0] adc_sample,
    output logic signed [bcc_pkg::MV_W-1:0]     battery_mv
);

    localparam int CALC_W = bcc_pkg::SAMPLE_W + bcc_pkg::FILTER_SHIFT + 1 > bcc_pkg::ACC_W + 2
                          ? bcc_pkg::SAMPLE_W + bcc_pkg::FILTER_SHIFT + 1
                          : bcc_pkg::ACC_W + 2;
    localparam logic signed [CALC_W-1:0] ACC_HI = CALC_W'((64'sd1 <<< (bcc_pkg::ACC_W - 1)) - 1);
    localparam logic signed [CALC_W-1:0] ACC_LO = CALC_W'(-(64'sd1 <<< (bcc_pkg::ACC_W - 1)));
    localparam logic signed [bcc_pkg::ACC_W-1:0] MV_HI =
        bcc_pkg::ACC_W'((64'sd1 <<< (bcc_pkg::MV_W - 1)) - 1);
    localparam logic signed [bcc_pkg::ACC_W-1:0] MV_LO =
        bcc_pkg::ACC_W'(-(64'sd1 <<< (bcc_pkg::MV_W - 1)));

    logic signed [bcc_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                             primed_reg, primed_next;
    logic signed [CALC_W-1:0]         acc_ext, smp_ext, acc_calc;
    logic signed [bcc_pkg::ACC_W-1:0] mv_wide;

    always_comb begin
        acc_ext = CALC_W'(acc_reg);
        smp_ext = CALC_W'(adc_sample);
        if (primed_reg) begin
            acc_calc = acc_ext - (acc_ext >>> bcc_pkg::FILTER_SHIFT) + smp_ext;
        end else begin
            acc_calc = smp_ext <<< bcc_pkg::FILTER_SHIFT;
        end

        acc_next    = acc_reg;
        primed_next = primed_reg;
        if (sample_valid) begin
            primed_next = 1'b1;
            if (acc_calc > ACC_HI) begin
                acc_next = bcc_pkg::ACC_W'(ACC_HI);
            end else if (acc_calc < ACC_LO) begin
                acc_next = bcc_pkg::ACC_W'(ACC_LO);
            end else begin
                acc_next = acc_calc[bcc_pkg::ACC_W-1:0];
            end
        end

        // voltage is twice the half-voltage reading
        mv_wide = acc_next >>> (bcc_pkg::FILTER_SHIFT - 1);
        if (mv_wide > MV_HI) begin
            battery_mv = MV_HI[bcc_pkg::MV_W-1:0];
        end else if (mv_wide < MV_LO) begin
            battery_mv = MV_LO[bcc_pkg::MV_W-1:0];
        end else begin
            battery_mv = mv_wide[bcc_pkg::MV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            primed_reg <= 1'b0;
        end else if (step_en) begin
            acc_reg    <= acc_next;
            primed_reg <= primed_next;
        end
    end

endmodule

>>> design/bcc_mode.sv
// bcc_mode: fault checks, charge/discharge sequence, dac code and amplifier enable
// depends on bcc_pkg

module bcc_mode (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic                            charge_mode,
    input  logic                            over_voltage,
    input  logic signed [bcc_pkg::MV_W-1:0] battery_mv,
    input  bcc_pkg::bcc_cfg_t               cfg,
    output bcc_pkg::bcc_result_t            result
);

    logic [bcc_pkg::STATE_W-1:0] state_reg, state_next;
    logic [bcc_pkg::CODE_W-1:0]  dac_reg, dac_next;
    logic                        amp_reg, amp_next;

    logic signed [bcc_pkg::MV_W:0] mv, amv, target, stop, too_low, open_chg, open_dis;
    logic                          fault;
    logic [bcc_pkg::STATE_W-1:0]   fault_state;

    always_comb begin
        mv       = (bcc_pkg::MV_W+1)'(battery_mv);
        amv      = mv[bcc_pkg::MV_W] ? -mv : mv;
        target   = (bcc_pkg::MV_W+1)'(cfg.target_mv);
        stop     = (bcc_pkg::MV_W+1)'($signed(cfg.dis_floor_mv));
        too_low  = (bcc_pkg::MV_W+1)'(cfg.too_low_mv);
        open_chg = (bcc_pkg::MV_W+1)'(cfg.open_charge_mv);
        open_dis = (bcc_pkg::MV_W+1)'(cfg.open_discharge_mv);

        // over voltage first, then no battery, then too low
        fault       = 1'b1;
        fault_state = bcc_pkg::ST_NONE;
        priority if (over_voltage) begin
            fault_state = bcc_pkg::ST_HIGHVOLT;
        end else if ((charge_mode && mv > open_chg) || (!charge_mode && amv < open_dis)) begin
            fault_state = bcc_pkg::ST_NONE;
        end else if (amv < too_low) begin
            fault_state = bcc_pkg::ST_TOOLOW;
        end else begin
            fault = 1'b0;
        end

        if (fault) begin
            state_next = fault_state;
        end else if (charge_mode) begin
            unique case (state_reg)
                bcc_pkg::ST_CC:
                    state_next = (mv < target) ? bcc_pkg::ST_CC : bcc_pkg::ST_CV;
                bcc_pkg::ST_CV:
                    state_next = (dac_reg != '0) ? bcc_pkg::ST_CV : bcc_pkg::ST_CHARGED;
                bcc_pkg::ST_CHARGED:
                    state_next = bcc_pkg::ST_CHARGED;
                default:
                    state_next = (mv < target) ? bcc_pkg::ST_CC : bcc_pkg::ST_CHARGED;
            endcase
        end else begin
            unique case (state_reg)
                bcc_pkg::ST_DIS:
                    state_next = (mv > stop) ? bcc_pkg::ST_DIS : bcc_pkg::ST_DISCHARGED;
                bcc_pkg::ST_DISCHARGED:
                    state_next = bcc_pkg::ST_DISCHARGED;
                default:
                    state_next = bcc_pkg::ST_DIS;
            endcase
        end

        dac_next = dac_reg;
        amp_next = amp_reg;
        unique case (state_next)
            bcc_pkg::ST_CC: begin
                dac_next = cfg.charge_code & bcc_pkg::DAC_MASK;
                amp_next = 1'b1;
            end
            bcc_pkg::ST_DIS: begin
                dac_next = cfg.discharge_code & bcc_pkg::DAC_MASK;
                amp_next = 1'b1;
            end
            bcc_pkg::ST_CV: begin
                // taper one code per step while at or above target
                if (mv >= target) begin
                    if (dac_reg > bcc_pkg::CODE_W'(1)) begin
                        dac_next = dac_reg - bcc_pkg::CODE_W'(1);
                    end else begin
                        dac_next = '0;
                        amp_next = 1'b0;
                    end
                end
            end
            default: begin
                dac_next = '0;
                amp_next = 1'b0;
            end
        endcase

        result.charge_state = state_next;
        result.dac_code     = dac_next;
        result.amp_enable   = amp_next;
        result.battery_mv   = battery_mv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcc_pkg::ST_NONE;
            dac_reg   <= '0;
            amp_reg   <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
            dac_reg   <= dac_next;
            amp_reg   <= amp_next;
        end
    end

endmodule

>>> design/battery_charge_controller.sv
// battery_charge_controller: top level, input and result registers, config registers
// depends on bcc_pkg, bcc_filter, bcc_mode
//
//   channel  dir  ports                         contents
//   s_       in   s_tvalid s_tready s_tdata     one control step, flag in s_tuser
//   m_       out  m_tvalid m_tready m_tdata     one result per control step
//   cfg_     in   cfg_wr_en cfg_index cfg_data  register write, no read-back
//
// one step per cycle sustained while m_tready stays high; a step passes from input beat to result beat through
// the input register, then filter, fault check and sequencer logic into the result register.
// the input register accepts a new beat while a finished result waits to be taken.
// a stalled m_ side holds one result and one pending step, then s_tready drops.
// aresetn (synchronous) clears the filter, the sequencer (no battery, dac 0, amp off)
// and restores the register defaults.

module battery_charge_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // adc_sample[12:0], charge_mode[13], over_voltage[14], zero
    input  logic        s_tuser,    // sample_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // charge_state[2:0], dac_code[10:3], amp_enable[11],
                                    // battery_mv[26:12], zero
    input  logic        cfg_wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data
);

    bcc_pkg::bcc_cfg_t    cfg_reg;
    bcc_pkg::bcc_item_t   item_reg;
    bcc_pkg::bcc_result_t res_reg, res_next;
    logic                 in_vld_reg, in_vld_next;
    logic                 out_vld_reg, out_vld_next;
    logic                 s_accept, fire;
    logic signed [bcc_pkg::MV_W-1:0] battery_mv;

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (fire) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.sample_valid <= s_tuser;
            item_reg.adc_sample   <= s_tdata[12:0];
            item_reg.charge_mode  <= s_tdata[13];
            item_reg.over_voltage <= s_tdata[14];
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_code       <= 8'd50;
            cfg_reg.discharge_code    <= 8'd250;
            cfg_reg.target_mv         <= 14'd4350;
            cfg_reg.dis_floor_mv      <= 15'd3000;
            cfg_reg.too_low_mv        <= 14'd900;
            cfg_reg.open_charge_mv    <= 14'd4900;
            cfg_reg.open_discharge_mv <= 14'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bcc_pkg::REG_CHARGE_CODE:    cfg_reg.charge_code <= cfg_data[7:0];
                bcc_pkg::REG_DISCHARGE_CODE: cfg_reg.discharge_code <= cfg_data[7:0];
                bcc_pkg::REG_TARGET_MV:      cfg_reg.target_mv <= cfg_data[13:0];
                bcc_pkg::REG_DIS_STOP_MV:    cfg_reg.dis_floor_mv <= cfg_data;
                bcc_pkg::REG_TOO_LOW_MV:     cfg_reg.too_low_mv <= cfg_data[13:0];
                bcc_pkg::REG_OPEN_CHG_MV:    cfg_reg.open_charge_mv <= cfg_data[13:0];
                bcc_pkg::REG_OPEN_DIS_MV:    cfg_reg.open_discharge_mv <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    bcc_filter u_filter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (fire),
        .sample_valid (item_reg.sample_valid),
        .adc_sample   ($signed(item_reg.adc_sample)),
        .battery_mv   (battery_mv)
    );

    bcc_mode u_mode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (fire),
        .charge_mode  (item_reg.charge_mode),
        .over_voltage (item_reg.over_voltage),
        .battery_mv   (battery_mv),
        .cfg          (cfg_reg),
        .result       (res_next)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, res_reg.battery_mv, res_reg.amp_enable,
                       res_reg.dac_code, res_reg.charge_state};

    // a held step never gets overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input register full with no room downstream expected");

    // a processed step always shows up as a result next cycle
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("step processed but no result beat");

    // idle and fault states drive no current
    a_idle_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res_reg.charge_state == bcc_pkg::ST_NONE
                   || res_reg.charge_state == bcc_pkg::ST_CHARGED
                   || res_reg.charge_state == bcc_pkg::ST_DISCHARGED
                   || res_reg.charge_state == bcc_pkg::ST_HIGHVOLT
                   || res_reg.charge_state == bcc_pkg::ST_TOOLOW))
        |-> (res_reg.dac_code == '0 && !res_reg.amp_enable))
        else $error("current enabled in an idle or fault state");

    // constant current and discharge always drive the amplifier
    a_active_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res_reg.charge_state == bcc_pkg::ST_CC
                   || res_reg.charge_state == bcc_pkg::ST_DIS))
        |-> res_reg.amp_enable)
        else $error("amplifier off in an active state");

endmodule
